@@ rtl/mm3_pkg.sv @@
// ----------------------------------------------------------------------------
// mm3_pkg: shared types and constants for the MurmurHash3 stream hasher
// Request codes, mode codes, mixing constants and the queued command format.
// ----------------------------------------------------------------------------
package mm3_pkg;

  localparam logic REQ_BYTE   = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  localparam logic MODE_X86_32  = 1'b0;
  localparam logic MODE_X64_128 = 1'b1;

  localparam int unsigned QueueDepth = 2;

  localparam logic [63:0] C1_32  = 64'h0000_0000_cc9e_2d51;
  localparam logic [63:0] C2_32  = 64'h0000_0000_1b87_3593;
  localparam logic [63:0] C1_64  = 64'h87c3_7b91_1142_53d5;
  localparam logic [63:0] C2_64  = 64'h4cf5_ad43_2745_937f;
  localparam logic [63:0] FM32_A = 64'h0000_0000_85eb_ca6b;
  localparam logic [63:0] FM32_B = 64'h0000_0000_c2b2_ae35;
  localparam logic [63:0] FM64_A = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] FM64_B = 64'hc4ce_b9fe_1a85_ec53;
  localparam logic [31:0] ADD_32 = 32'he654_6b64;
  localparam logic [63:0] ADD_H1 = 64'h0000_0000_52dc_e729;
  localparam logic [63:0] ADD_H2 = 64'h0000_0000_3849_5ab5;

  // One unit of work for the mixing engine: a full block or a finish.
  typedef struct packed {
    logic          fin;
    logic          mode;
    logic [3:0]    tail;
    logic [63:0]   len;
    logic [127:0]  blk;
  } cmd_t;

  localparam int unsigned CmdWidth = $bits(cmd_t);

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
    rotl32 = (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
    rotl64 = (x << r) | (x >> (64 - r));
  endfunction

endpackage

@@ rtl/mm3_if.sv @@
// ----------------------------------------------------------------------------
// mm3 channel interfaces
// Valid/ready channels for requests, hash results and the mode register.
// ----------------------------------------------------------------------------
interface mm3_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface mm3_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_high;
  logic [63:0] hash_low;
  modport source (output valid, output hash_high, output hash_low, input ready);
  modport sink   (input valid, input hash_high, input hash_low, output ready);
endinterface

interface mm3_cfg_if;
  logic valid;
  logic ready;
  logic mode_select;
  modport source (output valid, output mode_select, input ready);
  modport sink   (input valid, input mode_select, output ready);
endinterface

@@ rtl/mm3_queue.sv @@
// ----------------------------------------------------------------------------
// mm3_queue: small command FIFO
// Decouples the byte gatherer from the mixing engine.
// ----------------------------------------------------------------------------
module mm3_queue #(
  parameter int unsigned Width = mm3_pkg::CmdWidth,
  parameter int unsigned Depth = mm3_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);
  localparam logic [CW-1:0] FullCnt = CW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastIdx) ? '0 : wr_q + AW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastIdx) ? '0 : rd_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

@@ rtl/mm3_front.sv @@
// ----------------------------------------------------------------------------
// mm3_front: request intake and block gathering
// Buffers message bytes, counts length, and queues full blocks and finishes.
// ----------------------------------------------------------------------------
module mm3_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             mode_i,
  mm3_in_if.sink           in_chan,
  input  logic             q_full_i,
  output logic             push_o,
  output mm3_pkg::cmd_t    cmd_o
);
  logic [15:0][7:0] store_q, blk_d;
  logic [4:0]       held_q, held_inc, bsize;
  logic [63:0]      len_q;
  logic             acc, is_fin, blk_full;

  assign in_chan.ready = !q_full_i;
  assign acc      = in_chan.valid && in_chan.ready;
  assign is_fin   = (in_chan.req_type == mm3_pkg::REQ_FINISH);
  assign bsize    = (mode_i == mm3_pkg::MODE_X64_128) ? 5'd16 : 5'd4;
  assign held_inc = held_q + 5'd1;
  assign blk_full = (held_inc >= bsize);

  always_comb begin
    blk_d = store_q;
    blk_d[held_q[3:0]] = in_chan.data_byte;
  end

  assign push_o     = acc && (is_fin || blk_full);
  assign cmd_o.fin  = is_fin;
  assign cmd_o.mode = mode_i;
  assign cmd_o.tail = (mode_i == mm3_pkg::MODE_X64_128) ? held_q[3:0] : {2'b00, held_q[1:0]};
  assign cmd_o.len  = len_q;
  assign cmd_o.blk  = is_fin ? store_q : blk_d;

  always_ff @(posedge clk_i) begin
    if (acc && !is_fin) begin
      store_q <= blk_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      len_q  <= '0;
    end else if (acc) begin
      if (is_fin) begin
        held_q <= '0;
        len_q  <= '0;
      end else begin
        held_q <= blk_full ? 5'd0 : held_inc;
        len_q  <= len_q + 64'd1;
      end
    end
  end

endmodule

@@ rtl/mm3_back.sv @@
// ----------------------------------------------------------------------------
// mm3_back: mixing engine
// Sequencer around one 32x32 multiplier; 64-bit products are built from partial products.
// ----------------------------------------------------------------------------
module mm3_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  mm3_pkg::cmd_t cmd_i,
  output logic          pop_o,
  mm3_out_if.source     out_chan
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_K1A  = 4'd1;
  localparam logic [3:0] S_K1B  = 4'd2;
  localparam logic [3:0] S_K2A  = 4'd3;
  localparam logic [3:0] S_K2B  = 4'd4;
  localparam logic [3:0] S_H1   = 4'd5;
  localparam logic [3:0] S_H2   = 4'd6;
  localparam logic [3:0] S_F1   = 4'd7;
  localparam logic [3:0] S_F2   = 4'd8;
  localparam logic [3:0] S_F3   = 4'd9;
  localparam logic [3:0] S_FM1  = 4'd10;
  localparam logic [3:0] S_FM2  = 4'd11;
  localparam logic [3:0] S_G1   = 4'd12;
  localparam logic [3:0] S_G2   = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  logic [3:0]  st_q, st_d;
  logic [1:0]  ph_q;
  logic [63:0] h1_q, h1_d, h2_q, h2_d, k1_q, k1_d, k2_q, k2_d, t_q, t_d;
  logic [63:0] len_q, prod_q, prod_d, op_a, op_b, pp;
  logic [63:0] hh_q, hl_q, x64, y64, p64;
  logic [31:0] mx, my, p32, x32;
  logic        fin_q, mode_q, lane_q, lane_d, out_valid_q, out_load, is_mul, wb;
  logic [127:0] masked;

  // Bytes past the tail count are stale from an earlier block.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      masked[i*8 +: 8] = (!cmd_i.fin || (4'(i) < cmd_i.tail)) ? cmd_i.blk[i*8 +: 8] : 8'h00;
    end
  end

  always_comb begin
    unique case (st_q)
      S_K1A:   begin op_a = k1_q; op_b = mode_q ? mm3_pkg::C1_64 : mm3_pkg::C1_32; end
      S_K1B:   begin op_a = k1_q; op_b = mode_q ? mm3_pkg::C2_64 : mm3_pkg::C2_32; end
      S_K2A:   begin op_a = k2_q; op_b = mm3_pkg::C2_64; end
      S_K2B:   begin op_a = k2_q; op_b = mm3_pkg::C1_64; end
      S_FM1:   begin op_a = t_q;  op_b = mode_q ? mm3_pkg::FM64_A : mm3_pkg::FM32_A; end
      S_FM2:   begin op_a = t_q;  op_b = mode_q ? mm3_pkg::FM64_B : mm3_pkg::FM32_B; end
      default: begin op_a = '0;   op_b = '0; end
    endcase
  end

  assign is_mul = (st_q == S_K1A) || (st_q == S_K1B) || (st_q == S_K2A) ||
                  (st_q == S_K2B) || (st_q == S_FM1) || (st_q == S_FM2);
  assign wb     = is_mul && (ph_q == 2'd3);

  // Low 64 bits of a*b: lo*lo, then the two cross terms shifted up.
  assign mx = (ph_q == 2'd2) ? op_a[63:32] : op_a[31:0];
  assign my = (ph_q == 2'd1) ? op_b[63:32] : op_b[31:0];
  assign pp = {32'd0, mx} * {32'd0, my};
  assign prod_d = (ph_q == 2'd0) ? pp : prod_q + {pp[31:0], 32'd0};
  assign p64 = prod_q;
  assign p32 = prod_q[31:0];

  assign out_load = (st_q == S_OUT) && (!out_valid_q || out_chan.ready);
  assign pop_o    = (st_q == S_IDLE) && !q_empty_i;

  always_comb begin
    st_d   = st_q;
    h1_d   = h1_q;
    h2_d   = h2_q;
    k1_d   = k1_q;
    k2_d   = k2_q;
    t_d    = t_q;
    lane_d = lane_q;
    x64    = '0;
    y64    = '0;
    x32    = '0;
    unique case (st_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          k1_d   = (cmd_i.mode == mm3_pkg::MODE_X64_128) ? masked[63:0] : {32'd0, masked[31:0]};
          k2_d   = masked[127:64];
          lane_d = 1'b0;
          st_d   = S_K1A;
        end
      end
      S_K1A: begin
        if (wb) begin
          k1_d = mode_q ? mm3_pkg::rotl64(p64, 31) : {32'd0, mm3_pkg::rotl32(p32, 15)};
          st_d = S_K1B;
        end
      end
      S_K1B: begin
        if (wb) begin
          k1_d = mode_q ? p64 : {32'd0, p32};
          st_d = mode_q ? S_K2A : (fin_q ? S_F1 : S_H1);
        end
      end
      S_K2A: begin
        if (wb) begin
          k2_d = mm3_pkg::rotl64(p64, 33);
          st_d = S_K2B;
        end
      end
      S_K2B: begin
        if (wb) begin
          k2_d = p64;
          st_d = fin_q ? S_F1 : S_H1;
        end
      end
      S_H1: begin
        if (mode_q == mm3_pkg::MODE_X64_128) begin
          x64  = mm3_pkg::rotl64(h1_q ^ k1_q, 27) + h2_q;
          h1_d = x64 + (x64 << 2) + mm3_pkg::ADD_H1;
          st_d = S_H2;
        end else begin
          x32  = mm3_pkg::rotl32(h1_q[31:0] ^ k1_q[31:0], 13);
          h1_d = {32'd0, x32 + (x32 << 2) + mm3_pkg::ADD_32};
          st_d = S_IDLE;
        end
      end
      S_H2: begin
        y64  = mm3_pkg::rotl64(h2_q ^ k2_q, 31) + h1_q;
        h2_d = y64 + (y64 << 2) + mm3_pkg::ADD_H2;
        st_d = S_IDLE;
      end
      S_F1: begin
        if (mode_q == mm3_pkg::MODE_X64_128) begin
          h1_d = h1_q ^ k1_q ^ len_q;
          h2_d = h2_q ^ k2_q ^ len_q;
          st_d = S_F2;
        end else begin
          x32  = h1_q[31:0] ^ k1_q[31:0] ^ len_q[31:0];
          t_d  = {32'd0, x32 ^ (x32 >> 16)};
          st_d = S_FM1;
        end
      end
      S_F2: begin
        h1_d = h1_q + h2_q;
        st_d = S_F3;
      end
      S_F3: begin
        h2_d = h2_q + h1_q;
        t_d  = h1_q ^ (h1_q >> 33);
        st_d = S_FM1;
      end
      S_FM1: begin
        if (wb) begin
          t_d  = mode_q ? (p64 ^ (p64 >> 33)) : {32'd0, p32 ^ (p32 >> 13)};
          st_d = S_FM2;
        end
      end
      S_FM2: begin
        if (wb) begin
          if (mode_q == mm3_pkg::MODE_X64_128) begin
            if (!lane_q) begin
              h1_d   = p64 ^ (p64 >> 33);
              t_d    = h2_q ^ (h2_q >> 33);
              lane_d = 1'b1;
              st_d   = S_FM1;
            end else begin
              h2_d = p64 ^ (p64 >> 33);
              st_d = S_G1;
            end
          end else begin
            h1_d = '0;
            h2_d = {32'd0, p32 ^ (p32 >> 16)};
            st_d = S_OUT;
          end
        end
      end
      S_G1: begin
        h1_d = h1_q + h2_q;
        st_d = S_G2;
      end
      S_G2: begin
        h2_d = h2_q + h1_q;
        st_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          h1_d = '0;
          h2_d = '0;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    k1_q   <= k1_d;
    k2_q   <= k2_d;
    t_q    <= t_d;
    prod_q <= prod_d;
    if (pop_o) begin
      fin_q  <= cmd_i.fin;
      mode_q <= cmd_i.mode;
      len_q  <= cmd_i.len;
    end
    if (out_load) begin
      hh_q <= h1_q;
      hl_q <= h2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      ph_q        <= '0;
      h1_q        <= '0;
      h2_q        <= '0;
      lane_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      ph_q   <= is_mul ? ph_q + 2'd1 : 2'd0;
      h1_q   <= h1_d;
      h2_q   <= h2_d;
      lane_q <= lane_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_chan.valid     = out_valid_q;
  assign out_chan.hash_high = hh_q;
  assign out_chan.hash_low  = hl_q;

  a_phase_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !is_mul |-> ph_q == 2'd0) else $error("multiplier phase left running");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> st_q == S_K1A) else $error("command popped outside idle");
  a_lane32: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_H1 && mode_q == mm3_pkg::MODE_X86_32) |=> h1_q[63:32] == 32'd0)
    else $error("32-bit lane has upper bits set");
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && st_q == S_IDLE) else $error("result not presented");

endmodule

@@ rtl/murmur3_stream_hash.sv @@
// ----------------------------------------------------------------------------
// murmur3_stream_hash: streaming MurmurHash3 (x86_32 / x64_128, seed zero)
// Top level: config register, byte front end, command queue, mixing engine.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  - one request per handshake: req_type byte (data_byte) or finish.
//   out_chan - one hash per finish request; hash_high/hash_low hold h1/h2 in
//              128-bit mode, zero and the 32-bit hash in 32-bit mode.
//   cfg_chan - mode_select (0 = x86_32, 1 = x64_128); always ready; write it
//              only while no hash is pending.
// Throughput: the front end takes one byte per cycle. Each full block steps
//   the engine through K1A, K1B, H1 (32-bit) or K1A, K1B, K2A, K2B, H1, H2
//   (128-bit); one 32x32 multiplier builds each 64-bit product. Bursts beyond
//   what the command queue absorbs stall in_chan.ready.
// Finish path: a finish request passes the queue, the tail and finalization
//   states and the output register, behind any queued blocks ahead of it.
// Reset: lanes, counters, queue and output valid clear; mode returns to 32-bit.
// Stall: a result waits in the output register; the engine holds a second
//   finished hash and the queue keeps taking requests until it fills.
// ----------------------------------------------------------------------------
module murmur3_stream_hash #(
  parameter int unsigned QDepth = mm3_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mm3_in_if.sink     in_chan,
  mm3_out_if.source  out_chan,
  mm3_cfg_if.sink    cfg_chan
);
  logic          mode_q;
  logic          push, pop, full, empty;
  mm3_pkg::cmd_t cmd_in, cmd_out;

  // Mode register: taken on every config request.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= mm3_pkg::MODE_X86_32;
    end else if (cfg_chan.valid) begin
      mode_q <= cfg_chan.mode_select;
    end
  end

  mm3_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .mode_i   (mode_q),
    .in_chan  (in_chan),
    .q_full_i (full),
    .push_o   (push),
    .cmd_o    (cmd_in)
  );

  mm3_queue #(
    .Width (mm3_pkg::CmdWidth),
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (cmd_out),
    .empty_o (empty)
  );

  mm3_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (empty),
    .cmd_i     (cmd_out),
    .pop_o     (pop),
    .out_chan  (out_chan)
  );

endmodule

@@ verif/tb_murmur3_stream_hash.sv @@
// ----------------------------------------------------------------------------
// tb_murmur3_stream_hash: self-checking testbench for the stream hasher
// Drives byte and finish requests in both modes, predicts each hash with an
// independent MurmurHash3 model and checks every result in order.
// ----------------------------------------------------------------------------
class mm3_scoreboard;
  // Hasher state mirrored from the request stream.
  logic          mode;
  logic [63:0]   lane_a;
  logic [63:0]   lane_b;
  logic [7:0]    blk [16];
  logic [4:0]    held;
  logic [63:0]   msg_len;
  logic [127:0]  hash_q [$];
  int            errors;
  int            hashes_seen;

  function new();
    mode = mm3_pkg::MODE_X86_32;
    errors = 0;
    hashes_seen = 0;
    clear_msg();
  endfunction

  function void clear_msg();
    lane_a = '0;
    lane_b = '0;
    held = '0;
    msg_len = '0;
    foreach (blk[i]) blk[i] = '0;
  endfunction

  function automatic logic [63:0] pick(int base, int n);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v[8*i +: 8] = blk[(base + i) & 15];
    return v;
  endfunction

  function automatic logic [31:0] rl32(logic [31:0] x, int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [63:0] rl64(logic [63:0] x, int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [31:0] scramble32(logic [31:0] k);
    k = k * 32'hcc9e2d51;
    k = rl32(k, 15);
    return k * 32'h1b873593;
  endfunction

  function automatic logic [63:0] scramble_a(logic [63:0] k);
    k = k * 64'h87c37b91114253d5;
    k = rl64(k, 31);
    return k * 64'h4cf5ad432745937f;
  endfunction

  function automatic logic [63:0] scramble_b(logic [63:0] k);
    k = k * 64'h4cf5ad432745937f;
    k = rl64(k, 33);
    return k * 64'h87c37b91114253d5;
  endfunction

  function automatic logic [31:0] avalanche32(logic [31:0] h);
    h ^= h >> 16;
    h = h * 32'h85ebca6b;
    h ^= h >> 13;
    h = h * 32'hc2b2ae35;
    h ^= h >> 16;
    return h;
  endfunction

  function automatic logic [63:0] avalanche64(logic [63:0] k);
    k ^= k >> 33;
    k = k * 64'hff51afd7ed558ccd;
    k ^= k >> 33;
    k = k * 64'hc4ceb9fe1a85ec53;
    k ^= k >> 33;
    return k;
  endfunction

  function void mix_block();
    logic [31:0] h;
    logic [63:0] h1, h2;
    if (mode == mm3_pkg::MODE_X86_32) begin
      h = lane_a[31:0] ^ scramble32(32'(pick(0, 4)));
      h = rl32(h, 13);
      h = h * 32'd5 + 32'he6546b64;
      lane_a = {32'h0, h};
    end else begin
      h1 = lane_a;
      h2 = lane_b;
      h1 ^= scramble_a(pick(0, 8));
      h1 = rl64(h1, 27) + h2;
      h1 = h1 * 64'd5 + 64'h52dce729;
      h2 ^= scramble_b(pick(8, 8));
      h2 = rl64(h2, 31) + h1;
      h2 = h2 * 64'd5 + 64'h38495ab5;
      lane_a = h1;
      lane_b = h2;
    end
  endfunction

  // Note one accepted request; a finish queues the expected hash.
  function void note_request(logic req, logic [7:0] data);
    int n;
    logic [31:0] h;
    logic [63:0] h1, h2;
    if (req == mm3_pkg::REQ_BYTE) begin
      blk[held[3:0]] = data;
      held = held + 5'd1;
      msg_len = msg_len + 64'd1;
      if (held >= ((mode == mm3_pkg::MODE_X64_128) ? 16 : 4)) begin
        mix_block();
        held = '0;
      end
      return;
    end
    if (mode == mm3_pkg::MODE_X86_32) begin
      n = held & 3;
      h = lane_a[31:0];
      if (n > 0) h ^= scramble32(32'(pick(0, n)));
      h ^= msg_len[31:0];
      hash_q.push_back({64'h0, 32'h0, avalanche32(h)});
    end else begin
      n = held & 15;
      h1 = lane_a;
      h2 = lane_b;
      if (n > 8) h2 ^= scramble_b(pick(8, n - 8));
      if (n > 0) h1 ^= scramble_a(pick(0, (n > 8) ? 8 : n));
      h1 ^= msg_len;
      h2 ^= msg_len;
      h1 += h2;
      h2 += h1;
      h1 = avalanche64(h1);
      h2 = avalanche64(h2);
      h1 += h2;
      h2 += h1;
      hash_q.push_back({h1, h2});
    end
    clear_msg();
  endfunction

  function void check_hash(logic [63:0] hi, logic [63:0] lo);
    logic [127:0] exp_h;
    hashes_seen++;
    if (hash_q.size() == 0) begin
      $display("%0t: unexpected hash %h_%h", $time, hi, lo);
      errors++;
      return;
    end
    exp_h = hash_q.pop_front();
    if (hi !== exp_h[127:64]) begin
      $display("%0t: hash_high exp %h got %h", $time, exp_h[127:64], hi);
      errors++;
    end
    if (lo !== exp_h[63:0]) begin
      $display("%0t: hash_low exp %h got %h", $time, exp_h[63:0], lo);
      errors++;
    end
  endfunction
endclass

module tb_murmur3_stream_hash;

  localparam int MaxCycles = 400000;
  localparam int DrainCycles = 200;

  logic clk_i;
  logic rst_ni;
  int   cycle_cnt;
  bit   hold_rx;      // forces a long receiver stall
  bit   rx_noise;     // random receiver stalls enabled
  int   byte_reqs;
  int   fin_reqs;
  int   mode_fins [2];

  mm3_in_if  in_chan ();
  mm3_out_if out_chan ();
  mm3_cfg_if cfg_chan ();

  mm3_scoreboard sb;

  murmur3_stream_hash u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source),
    .cfg_chan (cfg_chan.sink)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MaxCycles) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAIL murmur3_stream_hash");
      $finish;
    end
  end

  // Monitors: sample at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_chan.valid && out_chan.ready)
      sb.check_hash(out_chan.hash_high, out_chan.hash_low);
    if (rst_ni && in_chan.valid && in_chan.ready) begin
      sb.note_request(in_chan.req_type, in_chan.data_byte);
      if (in_chan.req_type == mm3_pkg::REQ_FINISH) begin
        fin_reqs++;
        mode_fins[sb.mode]++;
      end else begin
        byte_reqs++;
      end
    end
    if (rst_ni && cfg_chan.valid && cfg_chan.ready) sb.mode = cfg_chan.mode_select;
  end

  // Receiver: own stall pattern, a random ready (high three draws in four), low under hold_rx.
  always @(negedge clk_i) begin
    if (!rst_ni || hold_rx) out_chan.ready <= 1'b0;
    else if (!rx_noise) out_chan.ready <= 1'b1;
    else out_chan.ready <= ($urandom_range(0, 3) != 0);
  end

  // One request; waits for its handshake and leaves valid high.
  task automatic send_req(logic req, logic [7:0] data);
    in_chan.valid     <= 1'b1;
    in_chan.req_type  <= req;
    in_chan.data_byte <= data;
    do @(posedge clk_i); while (!in_chan.ready);
    @(negedge clk_i);
  endtask

  task automatic idle_input(int n);
    in_chan.valid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Sender gap model: mostly back to back, sometimes a random gap.
  task automatic maybe_gap();
    if ($urandom_range(0, 9) == 0) idle_input($urandom_range(1, 6));
  endtask

  task automatic send_msg(int len, int gaps);
    for (int i = 0; i < len; i++) begin
      send_req(mm3_pkg::REQ_BYTE, 8'($urandom));
      if (gaps) maybe_gap();
    end
    send_req(mm3_pkg::REQ_FINISH, 8'($urandom));
    if (gaps) maybe_gap();
  endtask

  // Pause until every expected hash is out, then let the engine settle.
  task automatic drain();
    idle_input(1);
    while (sb.hash_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_mode(logic m);
    drain();
    cfg_chan.valid       <= 1'b1;
    cfg_chan.mode_select <= m;
    do @(posedge clk_i); while (!cfg_chan.ready);
    @(negedge clk_i);
    cfg_chan.valid <= 1'b0;
  endtask

  int sent;

  initial begin
    sb = new();
    cycle_cnt = 0;
    byte_reqs = 0;
    fin_reqs = 0;
    mode_fins[0] = 0;
    mode_fins[1] = 0;
    hold_rx = 0;
    rx_noise = 0;
    rst_ni = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.req_type = mm3_pkg::REQ_BYTE;
    in_chan.data_byte = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.mode_select = mm3_pkg::MODE_X86_32;
    out_chan.ready = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, 32-bit mode from reset: empty message, byte extremes,
    // every tail length and an exact block.
    send_req(mm3_pkg::REQ_FINISH, 8'hff);
    send_req(mm3_pkg::REQ_BYTE, 8'h00);
    send_req(mm3_pkg::REQ_FINISH, 8'h00);
    send_req(mm3_pkg::REQ_BYTE, 8'hff);
    send_req(mm3_pkg::REQ_BYTE, 8'h80);
    send_req(mm3_pkg::REQ_FINISH, 8'h00);
    for (int i = 0; i < 4; i++) send_req(mm3_pkg::REQ_BYTE, 8'hff);
    send_req(mm3_pkg::REQ_FINISH, 8'h00);
    for (int i = 0; i < 7; i++) send_req(mm3_pkg::REQ_BYTE, 8'(8'h55 << (i & 1)));
    send_req(mm3_pkg::REQ_FINISH, 8'h00);

    // Directed, 128-bit mode: empty, tail of 9 (crosses into h2), one block, tail of 15.
    set_mode(mm3_pkg::MODE_X64_128);
    send_req(mm3_pkg::REQ_FINISH, 8'h00);
    for (int i = 0; i < 9; i++) send_req(mm3_pkg::REQ_BYTE, 8'hff);
    send_req(mm3_pkg::REQ_FINISH, 8'h00);
    send_msg(16, 0);
    send_msg(15, 0);

    // Random phases alternating modes; receiver stalls on its own pattern.
    rx_noise = 1;
    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      set_mode(ph[0] ? mm3_pkg::MODE_X64_128 : mm3_pkg::MODE_X86_32);
      for (int m = 0; m < 7; m++) begin
        // mostly short messages, now and then a long multi-block one
        int len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48)
                                          : $urandom_range(0, 17);
        send_msg(len, 1);
        sent += len + 1;
      end
      if (ph == 2) begin
        // long receiver hold while bursts keep coming: input must back up
        fork
          begin
            hold_rx = 1;
            repeat (400) @(negedge clk_i);
            hold_rx = 0;
          end
          for (int m = 0; m < 6; m++) send_msg($urandom_range(0, 20), 0);
        join
      end
    end

    // Mode change in the middle of a message (only reachable when idle):
    // a few bytes under 32-bit mode, then switch while bytes are held.
    set_mode(mm3_pkg::MODE_X86_32);
    send_req(mm3_pkg::REQ_BYTE, 8'h12);
    send_req(mm3_pkg::REQ_BYTE, 8'h34);
    set_mode(mm3_pkg::MODE_X64_128);
    send_msg(5, 0);
    send_req(mm3_pkg::REQ_BYTE, 8'hab);
    set_mode(mm3_pkg::MODE_X86_32);
    send_req(mm3_pkg::REQ_FINISH, 8'h00);
    for (int i = 0; i < 6; i++) send_req(mm3_pkg::REQ_BYTE, 8'($urandom));
    set_mode(mm3_pkg::MODE_X64_128);
    send_req(mm3_pkg::REQ_FINISH, 8'h00);

    drain();
    $display("covered %0d bytes, %0d finishes (%0d x86_32, %0d x64_128)",
             byte_reqs, fin_reqs, mode_fins[0], mode_fins[1]);
    $display("hashes checked: %0d, mismatches: %0d", sb.hashes_seen, sb.errors);
    if (sb.errors == 0 && sb.hash_q.size() == 0) begin
      $display("PASS murmur3_stream_hash");
    end else begin
      $display("FAIL murmur3_stream_hash");
    end
    $finish;
  end
endmodule

@@ murmur3_stream_hash.f @@
rtl/mm3_pkg.sv
rtl/mm3_if.sv
rtl/mm3_queue.sv
rtl/mm3_front.sv
rtl/mm3_back.sv
rtl/murmur3_stream_hash.sv
verif/tb_murmur3_stream_hash.sv
